[rtl/array_double_ended_queue_defines.svh]
// Assertion macros used by the double-ended queue top level.
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define ADQ_ASSERT_NOW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ADQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/adq_pkg.sv]
// Types and constants of the double-ended queue.
`timescale 1ns / 1ps
package adq_pkg;
	localparam int OP_W      = 3;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;
	localparam int OUT_PAD_W = M_TDATA_W - DATA_W - 1;

	localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_PEEK_FRONT = 3'd2,
		OP_PEEK_BACK  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_PUSH_FRONT = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_NONE,
		RES_MEM
	} res_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SHIFT,
		S_FRONT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic      load_req;
		logic      rd_head;
		logic      rd_tail;
		logic      wr_back;
		logic      wr_below_head;
		logic      wr_front0;
		logic      shift_start;
		logic      shift_step;
		logic      head_inc;
		logic      tail_dec;
		logic      res_load;
		res_sel_t  res_sel;
		status_t   res_status;
		logic      out_load;
	} adq_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            head_zero;
		logic            tail_full;
		logic            tail_zero;
		logic            idx_one;
		logic            out_free;
	} adq_stat_t;
endpackage

[rtl/array_double_ended_queue.sv]
// Top level of the array-based double-ended queue.
`timescale 1ns / 1ps
// Deque of DEPTH signed 32-bit words in a linear array with head and tail indexes;
// one request beat in, exactly one result beat out. The block works on one request
// at a time and takes the next one while the previous result still waits at the
// output. Back pushes, front pushes with a free slot below the head, front pushes onto
// an empty queue at slot zero, dropped pushes, empty reads and unused opcodes go from
// decode straight to the result; pops and peeks that find data first read the slot
// memory; a front push with the head at slot zero and n >= 1 elements stored first
// shifts every stored word up one slot, as the single slot memory moves one word up per
// cycle. The result beat appears in the same cycle as the next request can first be taken.
// No clearing pass is needed after reset.
`include "array_double_ended_queue_defines.svh"
module array_double_ended_queue #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [adq_pkg::S_TDATA_W-1:0] s_tdata,  // op[2:0], data_in[34:3], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [adq_pkg::M_TDATA_W-1:0] m_tdata,  // value_out[31:0], now_empty[32], zero pad
	output logic [adq_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);
	import adq_pkg::*;

	adq_cmd_t  cmd;
	adq_stat_t stat;
	logic [3:0] slot_wr;

	adq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	adq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	assign slot_wr = {cmd.wr_back, cmd.wr_below_head, cmd.wr_front0, cmd.shift_step};

	`ADQ_ASSERT_NOW(a_one_write, $onehot0(slot_wr), "two slot writes in one cycle")
	`ADQ_ASSERT_NOW(a_out_free, !cmd.out_load || !m_tvalid || m_tready, "result over a waiting beat")
	`ADQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second request taken")
endmodule

[rtl/adq_ctrl.sv]
// Controller state machine of the double-ended queue.
`timescale 1ns / 1ps
module adq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  adq_pkg::adq_stat_t stat,
	output adq_pkg::adq_cmd_t  cmd
);
	import adq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_sel    = RES_ZERO;
		cmd.res_status = STAT_DONE;
		s_tready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESULT;
				unique case (stat.op) inside
					OP_PUSH_BACK: begin
						cmd.res_load = 1'b1;
						if (stat.tail_full) begin
							cmd.res_status = STAT_FULL;
						end else begin
							cmd.wr_back = 1'b1;
						end
					end
					OP_POP_FRONT, OP_PEEK_FRONT: begin
						if (stat.empty) begin
							cmd.res_load   = 1'b1;
							cmd.res_sel    = RES_NONE;
							cmd.res_status = STAT_EMPTY;
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = S_READ;
						end
					end
					OP_PEEK_BACK, OP_POP_BACK: begin
						if (stat.empty) begin
							cmd.res_load   = 1'b1;
							cmd.res_sel    = RES_NONE;
							cmd.res_status = STAT_EMPTY;
						end else begin
							cmd.rd_tail = 1'b1;
							state_d     = S_READ;
						end
					end
					OP_PUSH_FRONT: begin
						if (!stat.head_zero) begin
							cmd.wr_below_head = 1'b1;
							cmd.res_load      = 1'b1;
						end else if (stat.tail_full) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_FULL;
						end else if (stat.tail_zero) begin
							cmd.wr_front0 = 1'b1;
							cmd.res_load  = 1'b1;
						end else begin
							cmd.shift_start = 1'b1;
							state_d         = S_SHIFT;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
					end
				endcase
			end
			S_READ: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_MEM;
				cmd.head_inc = (stat.op == OP_POP_FRONT);
				cmd.tail_dec = (stat.op == OP_POP_BACK);
				state_d      = S_RESULT;
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.idx_one) begin
					state_d = S_FRONT;
				end
			end
			S_FRONT: begin
				cmd.wr_front0 = 1'b1;
				cmd.res_load  = 1'b1;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

[rtl/adq_dp.sv]
// Datapath of the double-ended queue: slot memory, indexes, result and output registers.
`timescale 1ns / 1ps
module adq_dp #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  adq_pkg::adq_cmd_t                 cmd,
	output adq_pkg::adq_stat_t                stat,
	input  logic [adq_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [adq_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [adq_pkg::STATUS_W-1:0]      m_tuser
);
	import adq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;
	logic signed [DATA_W-1:0] data_q;
	logic        [OP_W-1:0]   op_q;
	logic        [CW-1:0]     head_q, tail_q, idx_q;
	logic        [CW-1:0]     head_m1, tail_m1, idx_m1, idx_m2;
	logic signed [DATA_W-1:0] res_value_q, value_q;
	status_t                  res_status_q, status_q;
	logic                     empty_q, m_tvalid_q;

	logic                     wr_en, rd_en;
	logic        [AW-1:0]     wr_addr, rd_addr;
	logic signed [DATA_W-1:0] wr_data;

	assign head_m1 = head_q - CW'(1);
	assign tail_m1 = tail_q - CW'(1);
	assign idx_m1  = idx_q - CW'(1);
	assign idx_m2  = idx_q - CW'(2);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q   <= s_tdata[OP_W-1:0];
			data_q <= s_tdata[OP_W+DATA_W-1:OP_W];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q[AW-1:0];
		wr_data = data_q;
		if (cmd.wr_back) begin
			wr_en = 1'b1;
		end
		if (cmd.wr_below_head) begin
			wr_en   = 1'b1;
			wr_addr = head_m1[AW-1:0];
		end
		if (cmd.wr_front0) begin
			wr_en   = 1'b1;
			wr_addr = '0;
		end
		if (cmd.shift_step) begin
			wr_en   = 1'b1;
			wr_addr = idx_q[AW-1:0];
			wr_data = rd_data_q;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q[AW-1:0];
		if (cmd.rd_head) begin
			rd_en = 1'b1;
		end
		if (cmd.rd_tail || cmd.shift_start) begin
			rd_en   = 1'b1;
			rd_addr = tail_m1[AW-1:0];
		end
		if (cmd.shift_step && !stat.idx_one) begin
			rd_en   = 1'b1;
			rd_addr = idx_m2[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.wr_below_head) begin
				head_q <= head_m1;
			end else if (cmd.head_inc) begin
				head_q <= head_q + CW'(1);
			end
			if (cmd.wr_back || cmd.wr_front0) begin
				tail_q <= tail_q + CW'(1);
			end else if (cmd.tail_dec) begin
				tail_q <= tail_m1;
			end
			if (cmd.shift_start) begin
				idx_q <= tail_q;
			end else if (cmd.shift_step) begin
				idx_q <= idx_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_sel)
				RES_NONE: res_value_q <= NONE_VALUE;
				RES_MEM:  res_value_q <= rd_data_q;
				default:  res_value_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q  <= res_value_q;
			status_q <= res_status_q;
			empty_q  <= (head_q >= tail_q);
		end
	end

	assign stat.op        = op_q;
	assign stat.empty     = (head_q >= tail_q);
	assign stat.head_zero = (head_q == '0);
	assign stat.tail_full = (tail_q == CW'(DEPTH));
	assign stat.tail_zero = (tail_q == '0);
	assign stat.idx_one   = (idx_q == CW'(1));
	assign stat.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, empty_q, value_q};
	assign m_tuser  = status_q;
endmodule
